[sv/tpfc_pkg.sv]
// Package for the texture pixel format converter.
// Holds the format codes, the register indexes, the stage payload structs and shared helpers.
package tpfc_pkg;

   typedef enum logic [2:0] {
      FMT_RGBA4444 = 3'd0,
      FMT_RGB565   = 3'd1,
      FMT_RGBA5551 = 3'd2,
      FMT_RGB888   = 3'd3,
      FMT_LUM8     = 3'd4,
      FMT_BGRA8888 = 3'd5,
      FMT_RGBA8888 = 3'd6
   } fmt_type;

   localparam logic REG_SOURCE_FORMAT = 1'b0;
   localparam logic REG_TARGET_FORMAT = 1'b1;

   localparam logic [2:0] FMT_RESET = 3'd6;

   typedef struct packed {
      logic [31:0] pixel;
      fmt_type     src;
      fmt_type     dst;
      logic        bypass;
   } decoded_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  a;
      fmt_type     dst;
      logic        bypass;
   } expanded_type;

   function automatic fmt_type fold_code(input logic [2:0] code);
      fmt_type f;
      case (code)
         3'd0: f = FMT_RGBA4444;
         3'd1: f = FMT_RGB565;
         3'd2: f = FMT_RGBA5551;
         3'd3: f = FMT_RGB888;
         3'd4: f = FMT_LUM8;
         3'd5: f = FMT_BGRA8888;
         default: f = FMT_RGBA8888;
      endcase
      return f;
   endfunction

   function automatic logic [2:0] size_of_format(input fmt_type f);
      logic [2:0] n;
      case (f)
         FMT_RGBA4444: n = 3'd2;
         FMT_RGB565:   n = 3'd2;
         FMT_RGBA5551: n = 3'd2;
         FMT_RGB888:   n = 3'd3;
         FMT_LUM8:     n = 3'd1;
         default:      n = 3'd4;
      endcase
      return n;
   endfunction

   // round(v*255/31) as (510*v + 31) / 62, the divide done by reciprocal multiplication
   function automatic logic [7:0] widen5(input logic [4:0] v);
      return 8'((32'(v) * 32'd8625630 + 32'd524303) >> 20);
   endfunction

   // round(v*255/63) as (510*v + 63) / 126, the divide done by reciprocal multiplication
   function automatic logic [7:0] widen6(input logic [5:0] v);
      return 8'((32'(v) * 32'd16977390 + 32'd2097207) >> 22);
   endfunction

endpackage

[sv/tpfc_if.sv]
// Stream channel interfaces for the pixel format converter.
// Depends on nothing; valid/ready handshake with the pixel payload.
interface tpfc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface tpfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_out;
   logic [2:0]  byte_count;

   modport source (output valid, output pixel_out, output byte_count, input ready);
   modport sink (input valid, input pixel_out, input byte_count, output ready);
endinterface

[sv/texture_pixel_format_converter_core.sv]
// Texture pixel format converter: one pixel of up to four bytes in, the same pixel out in
// another format. Three register stages (decode, expand to RGBA8888, pack and mask) in that
// order; one pixel per clock goes through when the result side keeps up, and each stage holds
// its beat while the next one is stalled. Formats are set through the APB registers at byte 0
// (source) and 4 (target); the user must write them only while the pipeline is empty, which
// the block itself does not enforce.
module texture_pixel_format_converter_core
   import tpfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tpfc_req_if.sink    req_port,
   tpfc_rsp_if.source  rsp_port,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [2:0]   source_format_ff;
   logic [2:0]   target_format_ff;
   logic         cfg_write;
   logic         s1_valid;
   logic         s1_ready;
   decoded_type  s1_data;
   logic         s2_valid;
   logic         s2_ready;
   expanded_type s2_data;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= FMT_RESET;
         target_format_ff <= FMT_RESET;
      end else if (cfg_write) begin
         case (paddr[2])
            REG_SOURCE_FORMAT: source_format_ff <= pwdata[2:0];
            REG_TARGET_FORMAT: target_format_ff <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SOURCE_FORMAT: prdata = {29'h0, source_format_ff};
         REG_TARGET_FORMAT: prdata = {29'h0, target_format_ff};
         default:           prdata = 32'h0;
      endcase
   end

   tpfc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .in_pixel  (req_port.pixel_in),
      .src_code  (source_format_ff),
      .dst_code  (target_format_ff),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   tpfc_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   tpfc_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_pixel (rsp_port.pixel_out),
      .out_count (rsp_port.byte_count)
   );

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_port.valid)
      else $error("result valid straight after reset");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_port.valid) |-> $past(s2_valid))
      else $error("result appeared without a beat in the expand stage");

   a_unused_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.byte_count == 3'd1 |-> rsp_port.pixel_out[31:8] == 24'h0)
      else $error("bytes beyond the one-byte result not zero");

   a_two_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.byte_count == 3'd2 |-> rsp_port.pixel_out[31:16] == 16'h0)
      else $error("bytes beyond the two-byte result not zero");
`endif

endmodule

[sv/tpfc_decode.sv]
// First stage: register the beat, fold the format codes and flag equal formats.
// Depends on tpfc_pkg.
module tpfc_decode
   import tpfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] in_pixel,
   input  logic [2:0]  src_code,
   input  logic [2:0]  dst_code,
   output logic        out_valid,
   input  logic        out_ready,
   output decoded_type out_data
);

   logic        valid_ff;
   decoded_type data_ff;
   decoded_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.pixel  = in_pixel;
      data_in.src    = fold_code(src_code);
      data_in.dst    = fold_code(dst_code);
      data_in.bypass = (data_in.src == data_in.dst);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/tpfc_expand.sv]
// Second stage: widen the source pixel to 8-bit R, G, B and A channels.
// Depends on tpfc_pkg.
module tpfc_expand
   import tpfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  decoded_type  in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output expanded_type out_data
);

   logic         valid_ff;
   expanded_type data_ff;
   expanded_type data_in;
   logic [15:0]  w;
   logic [31:0]  px;

   assign in_ready = !valid_ff || out_ready;
   assign px       = in_data.pixel;
   assign w        = px[15:0];

   always_comb begin
      data_in.pixel  = px;
      data_in.dst    = in_data.dst;
      data_in.bypass = in_data.bypass;
      case (in_data.src)
         FMT_RGBA4444: begin
            data_in.r = {w[15:12], w[15:12]};
            data_in.g = {w[11:8], w[11:8]};
            data_in.b = {w[7:4], w[7:4]};
            data_in.a = {w[3:0], w[3:0]};
         end
         FMT_RGB565: begin
            data_in.r = widen5(w[15:11]);
            data_in.g = widen6(w[10:5]);
            data_in.b = widen5(w[4:0]);
            data_in.a = 8'hFF;
         end
         FMT_RGBA5551: begin
            data_in.r = widen5(w[15:11]);
            data_in.g = widen5(w[10:6]);
            data_in.b = widen5(w[5:1]);
            data_in.a = {8{w[0]}};
         end
         FMT_RGB888: begin
            data_in.r = px[7:0];
            data_in.g = px[15:8];
            data_in.b = px[23:16];
            data_in.a = 8'hFF;
         end
         FMT_LUM8: begin
            data_in.r = px[7:0];
            data_in.g = px[7:0];
            data_in.b = px[7:0];
            data_in.a = 8'hFF;
         end
         FMT_BGRA8888: begin
            data_in.r = px[23:16];
            data_in.g = px[15:8];
            data_in.b = px[7:0];
            data_in.a = px[31:24];
         end
         default: begin
            data_in.r = px[7:0];
            data_in.g = px[15:8];
            data_in.b = px[23:16];
            data_in.a = px[31:24];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/tpfc_pack.sv]
// Third stage: pack the channels into the target format, mask to its size, hold the result.
// Depends on tpfc_pkg. Equal formats pass the source pixel unpacked, still masked.
module tpfc_pack
   import tpfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  expanded_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_pixel,
   output logic [2:0]   out_count
);

   logic        valid_ff;
   logic [31:0] pixel_ff;
   logic [2:0]  count_ff;
   logic [31:0] pixel_in;
   logic [2:0]  count_in;
   logic [31:0] packed_px;
   logic [31:0] mask;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      case (in_data.dst)
         FMT_RGBA4444: packed_px = {16'h0, in_data.r[7:4], in_data.g[7:4],
                                    in_data.b[7:4], in_data.a[7:4]};
         FMT_RGB565:   packed_px = {16'h0, in_data.r[7:3], in_data.g[7:2],
                                    in_data.b[7:3]};
         FMT_RGBA5551: packed_px = {16'h0, in_data.r[7:3], in_data.g[7:3],
                                    in_data.b[7:3], in_data.a[7]};
         FMT_RGB888:   packed_px = {8'h0, in_data.b, in_data.g, in_data.r};
         FMT_LUM8:     packed_px = {24'h0, in_data.r};
         FMT_BGRA8888: packed_px = {in_data.a, in_data.r, in_data.g, in_data.b};
         default:      packed_px = {in_data.a, in_data.b, in_data.g, in_data.r};
      endcase
      count_in = size_of_format(in_data.dst);
      case (count_in)
         3'd1:    mask = 32'h0000_00FF;
         3'd2:    mask = 32'h0000_FFFF;
         3'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
      pixel_in = (in_data.bypass ? in_data.pixel : packed_px) & mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
         count_ff <= count_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;
   assign out_count = count_ff;

endmodule

[test/tpfc_conversion_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the texture pixel format converter: tracks the format registers
// from the APB writes, predicts each accepted pixel and checks the result beats in order.
// Depends on tpfc_pkg for the format codes and register indexes.
module tpfc_conversion_checker
   import tpfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_pixel,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pixel,
   input  logic [2:0]  rsp_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [31:0] pixel;
      logic [2:0]  count;
   } converted_pixel_type;

   converted_pixel_type expected_pixels[$];
   converted_pixel_type oldest;
   logic [2:0]          source_code;
   logic [2:0]          target_code;

   function automatic fmt_type as_format(input logic [2:0] code);
      if (code == 3'd7) begin
         return FMT_RGBA8888;
      end
      return fmt_type'(code);
   endfunction

   function automatic logic [7:0] widen_channel(input logic [7:0] value, input int unsigned m);
      int unsigned scaled;
      scaled = 510 * (value & m) + m;
      return 8'(scaled / (2 * m));
   endfunction

   function automatic converted_pixel_type convert_pixel(input logic [2:0] src_code,
                                                         input logic [2:0] dst_code,
                                                         input logic [31:0] px);
      fmt_type             src;
      fmt_type             dst;
      logic [15:0]         w;
      logic [7:0]          r, g, b, a;
      logic [31:0]         word;
      converted_pixel_type res;
      src = as_format(src_code);
      dst = as_format(dst_code);
      w = px[15:0];
      case (src)
         FMT_RGBA4444: begin
            r = widen_channel(8'(w >> 12), 15);
            g = widen_channel(8'(w >> 8), 15);
            b = widen_channel(8'(w >> 4), 15);
            a = widen_channel(8'(w), 15);
         end
         FMT_RGB565: begin
            r = widen_channel(8'(w >> 11), 31);
            g = widen_channel(8'(w >> 5), 63);
            b = widen_channel(8'(w), 31);
            a = 8'hFF;
         end
         FMT_RGBA5551: begin
            r = widen_channel(8'(w >> 11), 31);
            g = widen_channel(8'(w >> 6), 31);
            b = widen_channel(8'(w >> 1), 31);
            a = w[0] ? 8'hFF : 8'h00;
         end
         FMT_RGB888: begin
            r = px[7:0];
            g = px[15:8];
            b = px[23:16];
            a = 8'hFF;
         end
         FMT_LUM8: begin
            r = px[7:0];
            g = px[7:0];
            b = px[7:0];
            a = 8'hFF;
         end
         FMT_BGRA8888: begin
            r = px[23:16];
            g = px[15:8];
            b = px[7:0];
            a = px[31:24];
         end
         default: begin
            r = px[7:0];
            g = px[15:8];
            b = px[23:16];
            a = px[31:24];
         end
      endcase
      case (dst)
         FMT_RGBA4444: word = {16'h0, r[7:4], g[7:4], b[7:4], a[7:4]};
         FMT_RGB565:   word = {16'h0, r[7:3], g[7:2], b[7:3]};
         FMT_RGBA5551: word = {16'h0, r[7:3], g[7:3], b[7:3], a[7]};
         FMT_RGB888:   word = {8'h0, b, g, r};
         FMT_LUM8:     word = {24'h0, r};
         FMT_BGRA8888: word = {a, r, g, b};
         default:      word = {a, b, g, r};
      endcase
      if (src == dst) begin
         word = px;
      end
      case (dst)
         FMT_RGBA4444, FMT_RGB565, FMT_RGBA5551: res.count = 3'd2;
         FMT_RGB888:                             res.count = 3'd3;
         FMT_LUM8:                               res.count = 3'd1;
         default:                                res.count = 3'd4;
      endcase
      case (res.count)
         3'd1:    res.pixel = word & 32'h0000_00FF;
         3'd2:    res.pixel = word & 32'h0000_FFFF;
         3'd3:    res.pixel = word & 32'h00FF_FFFF;
         default: res.pixel = word;
      endcase
      return res;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      source_code = FMT_RESET;
      target_code = FMT_RESET;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         source_code = FMT_RESET;
         target_code = FMT_RESET;
      end else begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(convert_pixel(source_code, target_code, req_pixel));
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_SOURCE_FORMAT) begin
               source_code = pwdata[2:0];
            end else begin
               target_code = pwdata[2:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               note_failure($sformatf("unexpected beat pixel_out=%h byte_count=%0d",
                                      rsp_pixel, rsp_count));
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_pixel !== oldest.pixel) begin
                  note_failure($sformatf("pixel_out expected %h actual %h",
                                         oldest.pixel, rsp_pixel));
               end
               if (rsp_count !== oldest.count) begin
                  note_failure($sformatf("byte_count expected %0d actual %0d",
                                         oldest.count, rsp_count));
               end
            end
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

[test/texture_pixel_format_converter_core_test.sv]
`timescale 1ns / 100ps
// Top of the pixel format converter testbench: clock, reset, APB format writes and
// pixel stimulus with random idling on both channels; the verdict comes from the checker.
// Depends on tpfc_pkg, the stream interfaces, the core and tpfc_conversion_checker.
module texture_pixel_format_converter_core_test;
   import tpfc_pkg::*;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   logic        idle_on;
   int          stall_left;
   int          fail_count;
   int          pending;

   tpfc_req_if req_bus ();
   tpfc_rsp_if rsp_bus ();

   texture_pixel_format_converter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   tpfc_conversion_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_pixel  (req_bus.pixel_in),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_pixel  (rsp_bus.pixel_out),
      .rsp_count  (rsp_bus.byte_count),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("[texture_pixel_format_converter_core] ERROR");
      $finish;
   end

   // stall the result side in short bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready = 1'b0;
         stall_left = $urandom_range(1, 5) - 1;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   task automatic send_pixel(input logic [31:0] px);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.pixel_in = px;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic reg_index, input logic [31:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {reg_index, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // drain, then write both formats; upper data bits are don't-care
   task automatic set_formats(input logic [2:0] src, input logic [2:0] dst);
      wait_drained();
      csr_write(REG_SOURCE_FORMAT, {$urandom_range(0, 1) ? 29'($urandom) : 29'h0, src});
      csr_write(REG_TARGET_FORMAT, {$urandom_range(0, 1) ? 29'($urandom) : 29'h0, dst});
   endtask

   function automatic logic [31:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int phase;
      reset = 1'b1;
      idle_on = 1'b1;
      stall_left = 0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.pixel_in = '0;
      rsp_bus.ready = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // formats as after reset
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h1234_5678);
      set_formats(FMT_RGBA4444, FMT_RGBA8888);
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hABCD_1234);
      set_formats(FMT_RGB565, FMT_RGBA8888);
      send_pixel(32'h0000_FFFF);
      send_pixel(32'h5A5A_0821);
      send_pixel(32'h0000_001F);
      set_formats(FMT_RGBA5551, FMT_RGBA8888);
      send_pixel(32'hFFFF_0001);
      send_pixel(32'h0000_FFFE);
      set_formats(FMT_LUM8, FMT_RGB888);
      send_pixel(32'h0000_00FF);
      send_pixel(32'hFFFF_FF80);
      set_formats(FMT_BGRA8888, FMT_RGBA4444);
      send_pixel(32'h8040_2010);
      set_formats(FMT_RGBA8888, FMT_LUM8);
      send_pixel(32'hFFFF_FF7F);
      set_formats(FMT_RGBA8888, FMT_RGBA5551);
      send_pixel(32'hFF00_FF80);
      send_pixel(32'h0000_007F);
      // unused code on both sides, then on the source side only
      set_formats(3'd7, 3'd7);
      send_pixel(32'hA5A5_A5A5);
      set_formats(3'd7, FMT_BGRA8888);
      send_pixel(32'h1122_3344);
      set_formats(FMT_RGB888, FMT_RGB565);
      send_pixel(32'hFFFF_FFFF);
      set_formats(FMT_RGBA4444, FMT_RGBA4444);
      send_pixel(32'hFFFF_FFFF);

      // every pair of codes, no idling in the last few
      for (phase = 0; phase < 64; phase++) begin
         set_formats(3'(phase / 8), 3'(phase % 8));
         idle_on = (phase < 56);
         repeat ($urandom_range(12, 22)) send_pixel(random_pixel());
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[texture_pixel_format_converter_core] OK");
      end else begin
         $display("[texture_pixel_format_converter_core] ERROR");
      end
      $finish;
   end

endmodule
